@@ design/pilot_afc_pi_loop_macros.svh @@
// assertion helpers for the loop design file
`ifndef PILOT_AFC_PI_LOOP_MACROS_SVH
`define PILOT_AFC_PI_LOOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define AFC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define AFC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/afc_pkg.sv @@
package afc_pkg;

	// defaults for the top level parameters
	localparam int FRAC_BITS_DEF    = 16;
	localparam int COUNTER_BITS_DEF = 12;

	// shared multiply-accumulate datapath widths
	localparam int MUL_W = 33;
	localparam int ACC_W = 66;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 28;
	localparam logic [CFG_IDX_W-1:0] REG_AFC_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGN_NEGATIVE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OSC_FREQ      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ_DEV  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_TICKS    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_TICKS    = 3'd6;

	// register reset values
	localparam logic [22:0] RST_INTEG_LIMIT  = 23'd1310720;
	localparam logic [15:0] RST_MAX_FREQ_DEV = 16'd3277;
	localparam int          RST_FAST_TICKS   = 3000;
	localparam logic [15:0] RST_INIT_TICKS   = 16'd3000;

	// loop coefficients, Q.16
	localparam int COEF_SHIFT = 16;
	localparam logic [16:0] C_LP1   = 17'd59638;
	localparam logic [16:0] C_LP2   = 17'd5898;
	localparam logic [16:0] C_SL1   = 17'd64881;
	localparam logic [16:0] C_SL2   = 17'd655;
	localparam logic [16:0] KI_FAST = 17'd70654;
	localparam logic [16:0] KP_FAST = 17'd6554;
	localparam logic [16:0] KI_SLOW = 17'd614;
	localparam logic [16:0] KP_SLOW = 17'd0;

	// accumulator operations
	typedef enum logic [1:0] {
		MAC_NOP,
		MAC_LOAD,
		MAC_ADD,
		MAC_SUB
	} mac_op_t;

endpackage

@@ design/afc_mac.sv @@
module afc_mac (
	input  logic                                 clk,
	input  afc_pkg::mac_op_t                     op,
	input  logic signed [afc_pkg::MUL_W-1:0]     a,
	input  logic signed [afc_pkg::MUL_W-1:0]     b,
	output logic signed [afc_pkg::ACC_W-1:0]     acc
);

	logic signed [afc_pkg::ACC_W-1:0] prod;
	logic signed [afc_pkg::ACC_W-1:0] acc_q;

	// one signed product per cycle
	assign prod = a * b;

	// accumulate under sequencer control
	always_ff @(posedge clk) begin
		unique case (op)
			afc_pkg::MAC_LOAD: acc_q <= prod;
			afc_pkg::MAC_ADD:  acc_q <= acc_q + prod;
			afc_pkg::MAC_SUB:  acc_q <= acc_q - prod;
			default:           acc_q <= acc_q;
		endcase
	end

	assign acc = acc_q;

endmodule

@@ design/pilot_afc_pi_loop.sv @@
// Pilot-tone frequency control loop. Every accepted item gives one result that
// shows the loop state after the item. A tick (action 1) goes through the tick
// update state to the done state; a pilot sample while the loop is on uses the
// one shared 33x33 multiply-accumulate unit, which runs scaling, cross product,
// both low-pass filters and the PI controller in turn; a sample while the loop
// is off goes straight to the done state. Only one item is in work at a time;
// a finished result waits in the output register while the next item is taken.
// The user must write configuration only while no item is in work; not enforced.
`include "pilot_afc_pi_loop_macros.svh"

module pilot_afc_pi_loop #(
	parameter int FRAC_BITS    = afc_pkg::FRAC_BITS_DEF,
	parameter int COUNTER_BITS = afc_pkg::COUNTER_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [afc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [afc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               action,
	input  logic signed [15:0]                 pilot_i,
	input  logic signed [15:0]                 pilot_q,
	input  logic [15:0]                        rx_gain,
	input  logic [15:0]                        level_att,
	input  logic                               guard_present,
	input  logic                               fast_mute,
	input  logic                               snr_alarm,
	input  logic                               guard_level_alarm,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [23:0]                 freq_offset,
	output logic signed [29:0]                 rx_freq,
	output logic                               loop_on,
	output logic                               fast_mode,
	output logic                               afc_fail
);

	localparam int AW     = afc_pkg::ACC_W;
	localparam int MW     = afc_pkg::MUL_W;
	localparam int SH_SMP = 39 - FRAC_BITS;
	localparam int TW     = (COUNTER_BITS > 12) ? COUNTER_BITS : 12;
	localparam int TC_MAX_I = (2 ** COUNTER_BITS) - 1;
	localparam int TC_RST_I = (afc_pkg::RST_FAST_TICKS > TC_MAX_I) ? TC_MAX_I
		: afc_pkg::RST_FAST_TICKS;
	localparam logic [TW-1:0] TC_MAX = TW'(TC_MAX_I);
	localparam logic [COUNTER_BITS-1:0] TC_RST = COUNTER_BITS'(TC_RST_I);
	localparam logic signed [AW-1:0] S32_MAX = AW'(64'sd2147483647);
	localparam logic signed [AW-1:0] S32_MIN = -AW'(64'sd2147483648);
	localparam logic signed [AW-1:0] S32_NMAX = -AW'(64'sd2147483647);

	typedef enum logic [4:0] {
		ST_IDLE, ST_GA, ST_SI, ST_SQ, ST_SQP, ST_DIFF, ST_X1, ST_X2, ST_DF,
		ST_L2, ST_EL, ST_S2, ST_ES, ST_INT, ST_OFF, ST_CHK, ST_TICK, ST_DONE
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] r;
		r = v;
		if (v > S32_MAX) r = S32_MAX;
		if (v < S32_MIN) r = S32_MIN;
		return r[31:0];
	endfunction

	function automatic logic signed [31:0] satd(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] r;
		r = v;
		if (v > S32_MAX) r = S32_MAX;
		if (v < S32_NMAX) r = S32_NMAX;
		return r[31:0];
	endfunction

	function automatic logic signed [AW-1:0] ext32(input logic signed [31:0] v);
		return AW'(v);
	endfunction

	function automatic logic signed [MW-1:0] op32(input logic signed [31:0] v);
		return {v[31], v};
	endfunction

	function automatic logic signed [MW-1:0] opc(input logic [16:0] c);
		return {16'b0, c};
	endfunction

	state_t state_q;

	// configuration registers
	logic        en_q, neg_q;
	logic [27:0] osc_q;
	logic [22:0] lim_q;
	logic [15:0] mfd_q;
	logic [11:0] ftt_q;

	// captured item
	logic               ok_q;
	logic signed [15:0] pi_q, pq_q;
	logic [15:0]        g_q, a_q;

	// loop state
	logic signed [31:0] prev_i_q, prev_q_q, el_q, es_q, integ_q, off_q;
	logic [COUNTER_BITS-1:0] tc_q;
	logic [15:0]             su_q;
	logic                    active_q, fast_q, fail_q;

	// datapath temporaries
	logic [31:0]        ga_q;
	logic signed [31:0] si_q, sq_q, di_q, dq_q, df_q;

	// output register
	logic               out_valid_q;
	logic signed [23:0] fo_q;
	logic signed [29:0] rx_q;
	logic               on_q, fm_q, ff_q;

	// shared unit
	afc_pkg::mac_op_t       mac_op;
	logic signed [MW-1:0]   mac_a, mac_b;
	logic signed [AW-1:0]   acc;

	afc_mac u_mac (
		.clk (clk),
		.op  (mac_op),
		.a   (mac_a),
		.b   (mac_b),
		.acc (acc)
	);

	logic signed [AW-1:0] acc_smp, acc_frac, acc_coef;
	logic [32:0]          off_abs, es_abs;
	logic signed [32:0]   off_ext;
	logic [COUNTER_BITS-1:0] tc_load, tc_nx;
	logic [15:0]          su_nx;
	logic                 fast_nx, active_nx;
	logic [TW-1:0]        ftt_ext;
	logic [16:0]          ki, kp;

	assign acc_smp  = acc >>> SH_SMP;
	assign acc_frac = acc >>> FRAC_BITS;
	assign acc_coef = acc >>> afc_pkg::COEF_SHIFT;

	assign off_ext = {off_q[31], off_q};
	assign off_abs = off_q[31] ? 33'(-off_ext) : 33'(off_ext);
	assign es_abs  = es_q[31] ? 33'(-{es_q[31], es_q}) : {1'b0, es_q};

	assign ki = fast_q ? afc_pkg::KI_FAST : afc_pkg::KI_SLOW;
	assign kp = fast_q ? afc_pkg::KP_FAST : afc_pkg::KP_SLOW;

	// tracking counter reload, saturated to the counter width
	assign ftt_ext = TW'(ftt_q);
	assign tc_load = COUNTER_BITS'((ftt_ext > TC_MAX) ? TC_MAX : ftt_ext);

	// tick update of counters and flags
	always_comb begin
		if ((es_abs > {17'b0, mfd_q}) && (tc_q == '0)) begin
			tc_nx = tc_load;
		end else if (tc_q != '0) begin
			tc_nx = tc_q - 1'b1;
		end else begin
			tc_nx = tc_q;
		end
		fast_nx   = (tc_nx != '0);
		su_nx     = (su_q != '0) ? su_q - 16'd1 : su_q;
		active_nx = en_q && (ok_q || (su_nx != '0));
	end

	// operands for the shared unit
	always_comb begin
		mac_op = afc_pkg::MAC_NOP;
		mac_a  = '0;
		mac_b  = '0;
		unique case (state_q)
			ST_GA: begin
				mac_op = afc_pkg::MAC_LOAD;
				mac_a  = {17'b0, g_q};
				mac_b  = {17'b0, a_q};
			end
			ST_SI: begin
				mac_op = afc_pkg::MAC_LOAD;
				mac_a  = MW'(pi_q);
				mac_b  = {1'b0, acc[31:0]};
			end
			ST_SQ: begin
				mac_op = afc_pkg::MAC_LOAD;
				mac_a  = MW'(pq_q);
				mac_b  = {1'b0, ga_q};
			end
			ST_X1: begin
				mac_op = afc_pkg::MAC_LOAD;
				mac_a  = op32(di_q);
				mac_b  = op32(sq_q);
			end
			ST_X2: begin
				mac_op = afc_pkg::MAC_SUB;
				mac_a  = op32(dq_q);
				mac_b  = op32(si_q);
			end
			ST_DF: begin
				mac_op = afc_pkg::MAC_LOAD;
				mac_a  = opc(afc_pkg::C_LP1);
				mac_b  = op32(el_q);
			end
			ST_L2: begin
				mac_op = afc_pkg::MAC_ADD;
				mac_a  = opc(afc_pkg::C_LP2);
				mac_b  = op32(df_q);
			end
			ST_EL: begin
				mac_op = afc_pkg::MAC_LOAD;
				mac_a  = opc(afc_pkg::C_SL1);
				mac_b  = op32(es_q);
			end
			ST_S2: begin
				mac_op = afc_pkg::MAC_ADD;
				mac_a  = opc(afc_pkg::C_SL2);
				mac_b  = op32(el_q);
			end
			ST_ES: begin
				mac_op = afc_pkg::MAC_LOAD;
				mac_a  = opc(ki);
				mac_b  = op32(el_q);
			end
			ST_INT: begin
				mac_op = afc_pkg::MAC_LOAD;
				mac_a  = opc(kp);
				mac_b  = op32(el_q);
			end
			default: begin
				mac_op = afc_pkg::MAC_NOP;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= 1'b0;
			neg_q  <= 1'b0;
			osc_q  <= '0;
			lim_q  <= afc_pkg::RST_INTEG_LIMIT;
			mfd_q  <= afc_pkg::RST_MAX_FREQ_DEV;
			ftt_q  <= 12'(afc_pkg::RST_FAST_TICKS);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				afc_pkg::REG_AFC_ENABLE:    en_q   <= cfg_data[0];
				afc_pkg::REG_SIGN_NEGATIVE: neg_q  <= cfg_data[0];
				afc_pkg::REG_OSC_FREQ:      osc_q  <= cfg_data[27:0];
				afc_pkg::REG_INTEG_LIMIT:   lim_q  <= cfg_data[22:0];
				afc_pkg::REG_MAX_FREQ_DEV:  mfd_q  <= cfg_data[15:0];
				afc_pkg::REG_FAST_TICKS:    ftt_q  <= cfg_data[11:0];
				// start-up count is only loaded by reset
				afc_pkg::REG_INIT_TICKS:    ;
				default: ;
			endcase
		end
	end

	// item capture, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pi_q  <= pilot_i;
			pq_q  <= pilot_q;
			g_q   <= rx_gain;
			a_q   <= level_att;
			ok_q  <= guard_present && !fast_mute && !snr_alarm && !guard_level_alarm;
		end
	end

	// datapath temporaries
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_SI:   ga_q <= acc[31:0];
			ST_SQ:   si_q <= sat32(acc_smp);
			ST_SQP:  sq_q <= sat32(acc_smp);
			ST_DIFF: begin
				di_q <= satd(ext32(si_q) - ext32(prev_i_q));
				dq_q <= satd(ext32(sq_q) - ext32(prev_q_q));
			end
			ST_DF:   df_q <= sat32(acc_frac);
			default: ;
		endcase
	end

	// sequencer, loop state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_i_q    <= '0;
			prev_q_q    <= '0;
			el_q        <= '0;
			es_q        <= '0;
			integ_q     <= '0;
			off_q       <= '0;
			tc_q        <= TC_RST;
			su_q        <= afc_pkg::RST_INIT_TICKS;
			active_q    <= 1'b0;
			fast_q      <= 1'b1;
			fail_q      <= 1'b0;
			out_valid_q <= 1'b0;
			fo_q        <= '0;
			rx_q        <= '0;
			on_q        <= 1'b0;
			fm_q        <= 1'b0;
			ff_q        <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (action) begin
							state_q <= ST_TICK;
						end else if (active_q) begin
							state_q <= ST_GA;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_GA:   state_q <= ST_SI;
				ST_SI:   state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_SQP;
				ST_SQP:  state_q <= ST_DIFF;
				ST_DIFF: begin
					prev_i_q <= si_q;
					prev_q_q <= sq_q;
					state_q  <= ST_X1;
				end
				ST_X1:   state_q <= ST_X2;
				ST_X2:   state_q <= ST_DF;
				ST_DF:   state_q <= ST_L2;
				ST_L2:   state_q <= ST_EL;
				ST_EL: begin
					el_q    <= sat32(acc_coef);
					state_q <= ST_S2;
				end
				ST_S2:   state_q <= ST_ES;
				ST_ES: begin
					es_q    <= sat32(acc_coef);
					state_q <= ST_INT;
				end
				ST_INT: begin
					integ_q <= sat32(ext32(integ_q) + acc_coef);
					state_q <= ST_OFF;
				end
				ST_OFF: begin
					off_q   <= sat32(acc_coef + ext32(integ_q));
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					// offset out of range: restart the loop
					if (off_abs > {10'b0, lim_q}) begin
						off_q   <= '0;
						el_q    <= '0;
						es_q    <= '0;
						integ_q <= '0;
						tc_q    <= tc_load;
					end
					state_q <= ST_DONE;
				end
				ST_TICK: begin
					tc_q     <= tc_nx;
					fast_q   <= fast_nx;
					su_q     <= su_nx;
					active_q <= active_nx;
					fail_q   <= en_q && (fast_nx || !active_nx);
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						fo_q        <= off_q[23:0];
						rx_q        <= 30'({5'b0, osc_q} + (neg_q ? -off_ext : off_ext));
						on_q        <= active_q;
						fm_q        <= fast_q;
						ff_q        <= fail_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign freq_offset = fo_q;
	assign rx_freq     = rx_q;
	assign loop_on     = on_q;
	assign fast_mode   = fm_q;
	assign afc_fail    = ff_q;

	`AFC_ASSERT_NXT(a_busy_after_transfer, in_valid && !in_stall, state_q != ST_IDLE, "item transfer did not start the sequencer")
	`AFC_ASSERT_NXT(a_offset_in_limit, state_q == ST_CHK, off_abs <= {10'b0, lim_q}, "offset above limit after range check")
	`AFC_ASSERT_NXT(a_done_holds_result, state_q == ST_DONE && out_valid_q && out_stall, state_q == ST_DONE, "result overwritten while output stalled")
	`AFC_ASSERT_NXT(a_tick_one_step, state_q == ST_TICK, state_q == ST_DONE, "tick update took more than one cycle")

endmodule
